// ===== rtl/lzwvwd_pkg.sv =====
// Shared constants for the variable-width LZW decoder.
// No dependencies.
package lzwvwd_pkg;

  localparam int unsigned CODE_CLEAR = 32'h100;   // clears dictionary
  localparam int unsigned CODE_END   = 32'h101;   // ends the stream
  localparam int unsigned FIRST_FREE = 32'h102;   // first dictionary code
  localparam int unsigned MIN_WIDTH  = 9;         // code width after clear
  localparam int unsigned LEAF_MAX   = 32'hff;    // largest root code

  localparam int unsigned BUF_W = 24;             // bit buffer width
  localparam int unsigned CNT_W = 5;              // bit count / code width

endpackage

// ===== rtl/lzw_variable_width_decoder_top.sv =====
// LZW decoder, 9 to MAX_CODE_BITS bit codes, LSB-first packed input.
// Depends on lzwvwd_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): each word is either an offered
//    compressed byte (in_op = 0, in_in_byte) or a pull of one decoded byte
//    (in_op = 1). Exactly one result word follows every input word.
//  - Result channel (out_valid / out_stall): out_accepted tells whether an
//    offered byte was taken; out_out_valid / out_out_byte / out_out_last
//    carry a pulled byte; out_ended and out_error are sticky status.
//  - One word is in flight at a time. An offer that completes no code, or
//    decodes clear/end/literal/error, goes straight to the hand-over state.
//    An offer that decodes a string code first walks the prefix chain in
//    the dictionary RAM, one RAM read per chain entry. A pull from the
//    expansion stack does one stack RAM read; a pull of the KwKwK extra
//    byte, or with nothing pending, goes straight to the hand-over state.
//  - When the receiver stalls, the result waits in the pending-result
//    registers and in_stall stays high until it can be handed over.
//  - Synchronous reset clears all control state; the two RAMs keep
//    whatever they hold and need no clearing pass (never read unwritten).
module lzw_variable_width_decoder_top
  import lzwvwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_accepted,
  output logic       out_out_valid,
  output logic [7:0] out_out_byte,
  output logic       out_out_last,
  output logic       out_ended,
  output logic       out_error
);

  localparam int CW    = MAX_CODE_BITS;          // code / address width
  localparam int SPW   = MAX_CODE_BITS + 1;      // stack pointer, free code
  localparam int DEPTH = 1 << MAX_CODE_BITS;
  localparam int TW    = MAX_CODE_BITS + 8;      // dictionary entry width

  localparam logic [CW-1:0]    C_CLEAR = CW'(CODE_CLEAR);
  localparam logic [CW-1:0]    C_END   = CW'(CODE_END);
  localparam logic [CW-1:0]    C_LEAF  = CW'(LEAF_MAX);
  localparam logic [SPW-1:0]   C_FIRST = SPW'(FIRST_FREE);
  localparam logic [CNT_W-1:0] W_MIN   = CNT_W'(MIN_WIDTH);
  localparam logic [CNT_W-1:0] W_MAX   = CNT_W'(MAX_CODE_BITS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRD  = 3'd1;  // issue chain read or finish walk
  localparam logic [2:0] S_WDAT = 3'd2;  // chain entry arrives
  localparam logic [2:0] S_PULL = 3'd3;  // stack byte arrives
  localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

  // RAMs
  logic [TW-1:0] tbl_mem [DEPTH];
  logic [7:0]    stk_mem [DEPTH];
  logic [TW-1:0] tbl_q;
  logic [7:0]    stk_q;

  logic          tbl_we;
  logic [CW-1:0] tbl_waddr, tbl_raddr;
  logic [TW-1:0] tbl_wdata;
  logic          stk_we;
  logic [CW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata;

  // state
  logic [2:0]       state_r, state_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] width_r, width_nxt;
  logic [SPW-1:0]   nfc_r, nfc_nxt;
  logic [CW-1:0]    prev_r, prev_nxt;
  logic             aclr_r, aclr_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic             xv_r, xv_nxt;
  logic [7:0]       xb_r, xb_nxt;
  logic             end_r, end_nxt;
  logic             err_r, err_nxt;

  // walk
  logic [CW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] code_r, code_nxt;
  logic          kw_r, kw_nxt;
  logic [7:0]    lastb_r, lastb_nxt;

  // pending result
  logic       racc_r, racc_nxt;
  logic       rv_r, rv_nxt;
  logic [7:0] rb_r, rb_nxt;
  logic       rl_r, rl_nxt;

  // output register
  logic       ov_r, ov_nxt;
  logic       oacc_r, oacc_nxt;
  logic       ofv_r, ofv_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       oend_r, oend_nxt;
  logic       oerr_r, oerr_nxt;

  // scratch
  logic [BUF_W-1:0] buf_fill, code_mask;
  logic [CNT_W-1:0] cnt_fill;
  logic [CW-1:0]    code;
  logic [7:0]       first;
  logic [SPW-1:0]   nfc_inc, width_pow, sp_dec;
  logic             pending;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_accepted  = oacc_r;
  assign out_out_valid = ofv_r;
  assign out_out_byte  = ob_r;
  assign out_out_last  = ol_r;
  assign out_ended     = oend_r;
  assign out_error     = oerr_r;

  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    nfc_nxt   = nfc_r;
    prev_nxt  = prev_r;
    aclr_nxt  = aclr_r;
    sp_nxt    = sp_r;
    xv_nxt    = xv_r;
    xb_nxt    = xb_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    walk_nxt  = walk_r;
    code_nxt  = code_r;
    kw_nxt    = kw_r;
    lastb_nxt = lastb_r;
    racc_nxt  = racc_r;
    rv_nxt    = rv_r;
    rb_nxt    = rb_r;
    rl_nxt    = rl_r;
    ov_nxt    = ov_r && out_stall;
    oacc_nxt  = oacc_r;
    ofv_nxt   = ofv_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    oend_nxt  = oend_r;
    oerr_nxt  = oerr_r;

    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    tbl_raddr = walk_r;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;

    pending   = (sp_r != '0) || xv_r;
    buf_fill  = buf_r | (BUF_W'(in_in_byte) << cnt_r);
    cnt_fill  = cnt_r + CNT_W'(8);
    code_mask = (BUF_W'(1) << width_r) - BUF_W'(1);
    code      = CW'(buf_fill & code_mask);
    sp_dec    = sp_r - SPW'(1);
    nfc_inc   = nfc_r + SPW'(1);
    width_pow = SPW'(1) << width_r;
    first     = sp_r[SPW-1] ? lastb_r : walk_r[7:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          racc_nxt  = 1'b0;
          rv_nxt    = 1'b0;
          rb_nxt    = '0;
          rl_nxt    = 1'b0;
          state_nxt = S_DONE;
          if (!in_op) begin
            if (!pending && !end_r && !err_r) begin
              racc_nxt = 1'b1;
              buf_nxt  = buf_fill;
              cnt_nxt  = cnt_fill;
              if (cnt_fill >= width_r) begin
                buf_nxt  = buf_fill >> width_r;
                cnt_nxt  = cnt_fill - width_r;
                code_nxt = code;
                if (aclr_r) begin
                  // literal right after a clear
                  aclr_nxt  = 1'b0;
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = code[7:0];
                  sp_nxt    = SPW'(1);
                  prev_nxt  = code;
                end else if (code == C_CLEAR) begin
                  width_nxt = W_MIN;
                  nfc_nxt   = C_FIRST;
                  aclr_nxt  = 1'b1;
                  prev_nxt  = code;
                end else if (code == C_END) begin
                  end_nxt  = 1'b1;
                  prev_nxt = code;
                end else if (SPW'(code) < nfc_r) begin
                  walk_nxt  = code;
                  kw_nxt    = 1'b0;
                  sp_nxt    = '0;
                  state_nxt = S_WRD;
                end else if (SPW'(code) == nfc_r) begin
                  // KwKwK: previous string plus its own first byte
                  walk_nxt  = prev_r;
                  kw_nxt    = 1'b1;
                  sp_nxt    = '0;
                  state_nxt = S_WRD;
                end else begin
                  err_nxt = 1'b1;
                end
              end
            end
          end else begin
            if (sp_r != '0) begin
              sp_nxt    = sp_dec;
              stk_raddr = CW'(sp_dec);
              rv_nxt    = 1'b1;
              rl_nxt    = (sp_dec == '0) && !xv_r;
              state_nxt = S_PULL;
            end else if (xv_r) begin
              rv_nxt = 1'b1;
              rb_nxt = xb_r;
              rl_nxt = 1'b1;
              xv_nxt = 1'b0;
            end
          end
        end
      end

      S_WRD: begin
        if (walk_r > C_LEAF && !sp_r[SPW-1]) begin
          tbl_raddr = walk_r;
          state_nxt = S_WDAT;
        end else begin
          if (!sp_r[SPW-1]) begin
            stk_we    = 1'b1;
            stk_waddr = CW'(sp_r);
            stk_wdata = walk_r[7:0];
            sp_nxt    = sp_r + SPW'(1);
          end
          if (kw_r) begin
            xv_nxt = 1'b1;
            xb_nxt = first;
          end
          if (!nfc_r[SPW-1]) begin
            tbl_we    = 1'b1;
            tbl_waddr = CW'(nfc_r);
            tbl_wdata = {prev_r, first};
            nfc_nxt   = nfc_inc;
            if (width_r < W_MAX && nfc_inc >= width_pow) begin
              width_nxt = width_r + CNT_W'(1);
            end
          end
          prev_nxt  = code_r;
          state_nxt = S_DONE;
        end
      end

      S_WDAT: begin
        stk_we    = 1'b1;
        stk_waddr = CW'(sp_r);
        stk_wdata = tbl_q[7:0];
        sp_nxt    = sp_r + SPW'(1);
        lastb_nxt = tbl_q[7:0];
        walk_nxt  = tbl_q[TW-1:8];
        state_nxt = S_WRD;
      end

      S_PULL: begin
        rb_nxt    = stk_q;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oacc_nxt  = racc_r;
          ofv_nxt   = rv_r;
          ob_nxt    = rb_r;
          ol_nxt    = rl_r;
          oend_nxt  = end_r;
          oerr_nxt  = err_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      buf_r   <= '0;
      cnt_r   <= '0;
      width_r <= W_MIN;
      nfc_r   <= C_FIRST;
      prev_r  <= '0;
      aclr_r  <= 1'b0;
      sp_r    <= '0;
      xv_r    <= 1'b0;
      end_r   <= 1'b0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      nfc_r   <= nfc_nxt;
      prev_r  <= prev_nxt;
      aclr_r  <= aclr_nxt;
      sp_r    <= sp_nxt;
      xv_r    <= xv_nxt;
      end_r   <= end_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xb_r     <= xb_nxt;
    walk_r   <= walk_nxt;
    code_r   <= code_nxt;
    kw_r     <= kw_nxt;
    lastb_r  <= lastb_nxt;
    racc_r   <= racc_nxt;
    rv_r     <= rv_nxt;
    rb_r     <= rb_nxt;
    rl_r     <= rl_nxt;
    oacc_r   <= oacc_nxt;
    ofv_r    <= ofv_nxt;
    ob_r     <= ob_nxt;
    ol_r     <= ol_nxt;
    oend_r   <= oend_nxt;
    oerr_r   <= oerr_nxt;
  end

endmodule

// ===== verif/lzw_variable_width_decoder_top_tb.sv =====
// Self-checking testbench for lzw_variable_width_decoder_top: builds legal LZW code streams,
// packs them LSB first into offered words and checks every result word against a local decoder.
// Depends on lzwvwd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module lzw_variable_width_decoder_top_tb
  import lzwvwd_pkg::*;
();

  localparam bit OP_OFFER = 1'b0;
  localparam bit OP_PULL  = 1'b1;
  localparam int unsigned TOP_BITS = 16;
  localparam int unsigned DICT_SZ  = 1 << TOP_BITS;
  localparam int unsigned RANDOM_WORDS = 400;

  typedef struct packed {
    logic       accepted;
    logic       byte_valid;
    logic [7:0] data;
    logic       last;
    logic       ended;
    logic       err;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = 1'b0;
  logic [7:0] in_in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_accepted, out_out_valid, out_out_last, out_ended, out_error;
  logic [7:0] out_out_byte;

  lzw_variable_width_decoder_top #(.MAX_CODE_BITS(TOP_BITS)) dut (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: mirrors the block state, updated as each word is accepted.
  // ---------------------------------------------------------------------------
  logic [23:0] dict_mem [DICT_SZ];
  logic [7:0]  string_stack [DICT_SZ];
  int unsigned bitbuf, bitcnt, code_w, free_code, prev_code, sp;
  bit          literal_next, extra_valid, end_flag, err_flag;
  logic [7:0]  extra_byte;

  result_t     decoded_q[$];     // results still owed by the block
  int          mismatches = 0;
  int          words_sent = 0;

  // Walk a code's prefix chain onto the stack; returns the string's first byte.
  function automatic logic [7:0] walk_chain(int unsigned code);
    int unsigned c;
    logic [23:0] e;
    c = code & 16'hffff;
    sp = 0;
    while (c > LEAF_MAX && sp < DICT_SZ) begin
      e = dict_mem[c];
      string_stack[sp] = e[7:0];
      sp++;
      c = 32'(e[23:8]);
    end
    if (sp < DICT_SZ) begin
      string_stack[sp] = c[7:0];
      sp++;
    end
    return string_stack[sp-1];
  endfunction

  function automatic void add_string(logic [7:0] first);
    if (free_code >= DICT_SZ) return;   // table full: stop growing
    dict_mem[free_code] = {prev_code[15:0], first};
    free_code++;
    if (code_w < TOP_BITS && free_code >= (1 << code_w)) code_w++;
  endfunction

  function automatic void decode_code(int unsigned code);
    logic [7:0] first;
    if (literal_next) begin
      literal_next = 0;
      string_stack[0] = code[7:0];
      sp = 1;
      prev_code = code & 16'hffff;
      return;
    end
    if (code == CODE_CLEAR) begin
      code_w = MIN_WIDTH;
      free_code = FIRST_FREE;
      literal_next = 1;
      prev_code = code;
      return;
    end
    if (code == CODE_END) begin
      end_flag = 1;
      prev_code = code;
      return;
    end
    if (code < free_code) begin
      add_string(walk_chain(code));
    end else if (code == free_code) begin
      // KwKwK: previous string plus its own first byte
      first = walk_chain(prev_code);
      extra_valid = 1;
      extra_byte = first;
      add_string(first);
    end else begin
      err_flag = 1;
      return;
    end
    prev_code = code & 16'hffff;
  endfunction

  function automatic result_t decode_word(bit op, logic [7:0] b);
    result_t r;
    int unsigned code;
    r = '0;
    if (op == OP_OFFER) begin
      if (sp == 0 && !extra_valid && !end_flag && !err_flag) begin
        r.accepted = 1;
        bitbuf = (bitbuf | (int'(b) << bitcnt)) & 32'hffffff;
        bitcnt += 8;
        if (bitcnt >= code_w) begin
          code = bitbuf & ((1 << code_w) - 1);
          bitbuf >>= code_w;
          bitcnt -= code_w;
          decode_code(code);
        end
      end
    end else if (sp != 0) begin
      sp--;
      r.byte_valid = 1;
      r.data = string_stack[sp];
      r.last = (sp == 0 && !extra_valid);
    end else if (extra_valid) begin
      extra_valid = 0;
      r.byte_valid = 1;
      r.data = extra_byte;
      r.last = 1;
    end
    r.ended = end_flag;
    r.err = err_flag;
    return r;
  endfunction

  function automatic bit bytes_pending();
    return sp != 0 || extra_valid;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------
  bit quiet = 0;        // no idling on either side
  bit hold_req = 0;     // asks for a long receiver hold-off
  bit hold_on = 0;

  task automatic send_word(bit op, logic [7:0] b);
    while (!quiet && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_in_byte <= b;
    do @(posedge clk); while (in_stall);
    decoded_q.push_back(decode_word(op, b));
    words_sent++;
    // drop valid so a caller that waits does not offer the word again
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver stall: random, or held high for a counted stretch on request.
  always @(negedge clk) begin
    out_stall <= hold_on || (!quiet && $urandom_range(99) < 37);
  end

  initial begin
    forever begin
      wait (hold_req);
      hold_on = 1;
      repeat (300) @(negedge clk);
      hold_on = 0;
      hold_req = 0;
    end
  end

  task automatic report(string what, result_t got, result_t want);
    mismatches++;
    $display("%0t mismatch %s: got %p want %p", $time, what, got, want);
  endtask

  // Each handed-over result against the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_accepted, out_out_valid, out_out_byte, out_out_last, out_ended, out_error};
      if (decoded_q.size() == 0) begin
        report("unexpected word", got, '0);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) report("result word", got, want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream builder: tracks the decoder's width and free code to emit legal codes.
  // ---------------------------------------------------------------------------
  int unsigned g_free = FIRST_FREE, g_w = MIN_WIDTH;
  bit          g_literal = 0;
  longint unsigned g_bits = 0;
  int unsigned g_cnt = 0;

  // Offer one word; drain (or poke with refused offers) while output is pending.
  task automatic feed_byte(logic [7:0] b);
    while (bytes_pending()) begin
      if ($urandom_range(7) == 0) send_word(OP_OFFER, 8'($urandom_range(255)));
      else send_word(OP_PULL, 8'($urandom_range(255)));
    end
    send_word(OP_OFFER, b);
  endtask

  task automatic emit_code(int unsigned code);
    g_bits |= longint'(code) << g_cnt;
    g_cnt += g_w;
    if (g_literal) begin
      g_literal = 0;
    end else if (code == CODE_CLEAR) begin
      g_free = FIRST_FREE;
      g_w = MIN_WIDTH;
      g_literal = 1;
    end else if (code <= g_free && code != CODE_END) begin
      if (g_free < DICT_SZ) begin
        g_free++;
        if (g_w < TOP_BITS && g_free >= (1 << g_w)) g_w++;
      end
    end
    while (g_cnt >= 8) begin
      feed_byte(g_bits[7:0]);
      g_bits >>= 8;
      g_cnt -= 8;
    end
  endtask

  // Literal after a clear stays below 0x100 so no unwritten entry becomes a prefix.
  function automatic int unsigned pick_code(int lit_pct);
    int unsigned r;
    if (g_literal) return $urandom_range(LEAF_MAX);
    r = $urandom_range(99);
    if (r < lit_pct) return $urandom_range(LEAF_MAX);
    if (r < lit_pct + 10) return g_free;                  // KwKwK
    if (r < lit_pct + 12) return CODE_CLEAR;
    if (g_free > FIRST_FREE) return $urandom_range(g_free - 1, FIRST_FREE);
    return $urandom_range(LEAF_MAX);
  endfunction

  task automatic drain_output();
    while (bytes_pending()) send_word(OP_PULL, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_word(OP_PULL, 8'h00);          // pull with nothing pending
    emit_code(FIRST_FREE);              // KwKwK as first code, prefix 0
    emit_code(LEAF_MAX);
    emit_code(0);
    emit_code(FIRST_FREE + 1);
    emit_code(FIRST_FREE + 3);          // string code already in the table
    emit_code(CODE_CLEAR);
    emit_code(8'haa);                   // literal after clear
    emit_code(FIRST_FREE);              // KwKwK right after clear literal
    emit_code(8'h55);
    drain_output();
    send_word(OP_PULL, 8'hff);
  endtask

  // Literals and KwKwK only, no idling: grows the table past the 9-bit range.
  task automatic test_width_growth();
    quiet = 1;
    while (g_w < 10) emit_code(pick_code(90));
    quiet = 0;
    drain_output();
  endtask

  task automatic test_random_streams();
    int unsigned start;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      emit_code(pick_code(45));
      if ($urandom_range(49) == 0) send_word(OP_PULL, 8'($urandom_range(255)));
    end
    drain_output();
  endtask

  // Receiver holds off while words keep coming: the block must stall its input.
  task automatic test_backpressure();
    hold_req = 1;
    repeat (12) emit_code(pick_code(60));
    drain_output();
    wait (!hold_req);
  endtask

  task automatic test_sender_pause();
    repeat (10) emit_code(pick_code(50));
    drain_output();
    wait (decoded_q.size() == 0);
    repeat (5) emit_code(pick_code(50));
    drain_output();
  endtask

  // Ends with either an end code or an out-of-range code; later offers are refused.
  task automatic test_stream_end();
    if (g_literal) emit_code($urandom_range(LEAF_MAX));   // finish a pending clear
    if (!g_literal && g_free + 1 < (1 << g_w) && $urandom_range(1))
      emit_code($urandom_range((1 << g_w) - 1, g_free + 1));
    else
      emit_code(CODE_END);
    if (g_cnt > 0) feed_byte(8'(g_bits[7:0] | ($urandom_range(255) << g_cnt)));
    g_cnt = 0;
    repeat (4) send_word(OP_OFFER, 8'($urandom_range(255)));
    drain_output();
    send_word(OP_PULL, 8'h00);
  endtask

  initial begin
    bitbuf = 0; bitcnt = 0; code_w = MIN_WIDTH; free_code = FIRST_FREE;
    prev_code = 0; sp = 0; literal_next = 0; extra_valid = 0;
    end_flag = 0; err_flag = 0; extra_byte = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_width_growth();
    test_backpressure();
    test_random_streams();
    test_sender_pause();
    test_stream_end();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
